// ----- rtl/pht_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packet header truncator package
// Shared constants, codes and types of the packet header truncator.
// ----------------------------------------------------------------------------
package pht_pkg;

    localparam int FILTER_ENTRIES = 16;
    localparam int MAX_VLAN_TAGS  = 2;

    localparam int FILT_IDX_W = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
    localparam int TAG_W      = (MAX_VLAN_TAGS > 0) ? $clog2(MAX_VLAN_TAGS + 1) : 1;
    localparam int L3_BASE    = 14;
    localparam int L3_W       = $clog2(L3_BASE + 4 * MAX_VLAN_TAGS + 1);
    localparam int CUT_W      = L3_W + 7;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 88;
    localparam int APB_AW    = 3;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_ENTRY = 1'b1;

    localparam logic [15:0] ET_VLAN_Q  = 16'h8100;
    localparam logic [15:0] ET_VLAN_AD = 16'h88A8;
    localparam logic [15:0] ET_IPV4    = 16'h0800;
    localparam logic [15:0] ET_IPV6    = 16'h86DD;

    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_TCP = 8'd6;

    localparam logic [7:0] UDP_HDR_LEN  = 8'd8;
    localparam logic [7:0] TCP_HDR_LEN  = 8'd20;
    localparam logic [7:0] IPV6_HDR_LEN = 8'd40;

    localparam logic [15:0] V4_OFS_VER    = 16'd0;
    localparam logic [15:0] V4_OFS_PROTO  = 16'd9;
    localparam logic [15:0] V4_OFS_SRC_LO = 16'd12;
    localparam logic [15:0] V4_OFS_SRC_HI = 16'd15;
    localparam logic [15:0] V4_OFS_END    = 16'd19;
    localparam logic [15:0] V6_OFS_PROTO  = 16'd6;
    localparam logic [15:0] V6_OFS_END    = 16'd39;

    localparam logic APB_ADDR_FILTER = 1'b0;

    typedef enum logic [5:0] {
        PH_ETH     = 6'b000001,
        PH_V4      = 6'b000010,
        PH_V6      = 6'b000100,
        PH_V4_FULL = 6'b001000,
        PH_V6_FULL = 6'b010000,
        PH_OTHER   = 6'b100000
    } t_phase;

endpackage
`default_nettype wire

// ----- rtl/packet_header_truncator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packet header truncator
// Parses Ethernet, VLAN tags and IPv4/IPv6 headers one byte per beat and
// reports, on the last byte, the length of the packet cut after its L4 header.
// ----------------------------------------------------------------------------
// The last byte passes the input register, then its result is registered in
// the result register. Throughput: one beat per cycle, unless a last byte
// waits on a result that the output has not taken. The filter table is compared in parallel.
// Reset is synchronous and active low; it clears the parse state, the filter
// valid bits, the packet count and the filter enable.
module packet_header_truncator_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // data_byte[7:0], entry_index[11:8], entry_address[43:12], entry_valid[44]
    input  wire  [pht_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // operation
    input  wire                                 s_axis_tuser,
    input  wire                                 s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // new_length[15:0], cut_beyond_end[16], truncated_count[80:17]
    output logic [pht_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // action
    output logic                                m_axis_tuser,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [pht_pkg::APB_AW-1:0]          paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // Input register
    logic                 r_s1_vld;
    logic                 r_s1_op;
    logic [7:0]           r_s1_byte;
    logic                 r_s1_last;
    logic [3:0]           r_s1_idx;
    logic [31:0]          r_s1_addr;
    logic                 r_s1_evld;

    // Parse state
    logic [15:0]                 r_pos,   n_pos;
    logic [15:0]                 r_kind,  n_kind;
    logic [pht_pkg::TAG_W-1:0]   r_tags,  n_tags;
    logic [pht_pkg::L3_W-1:0]    r_l3,    n_l3;
    pht_pkg::t_phase             r_phase, n_phase;
    logic [3:0]                  r_hw,    n_hw;
    logic [7:0]                  r_proto, n_proto;
    logic [31:0]                 r_src,   n_src;

    logic [31:0] r_taddr [pht_pkg::FILTER_ENTRIES];
    logic        r_tvld  [pht_pkg::FILTER_ENTRIES];
    logic [63:0] r_cnt;
    logic        r_fen;

    // Result register
    logic        r_out_vld;
    logic        r_out_action;
    logic [15:0] r_out_len;
    logic        r_out_beyond;
    logic [63:0] r_out_cnt;

    logic        w_is_pkt;
    logic        w_emits;
    logic        w_out_free;
    logic        w_s1_adv;
    logic        w_in_acc;
    logic [15:0] w_l3_ext;
    logic [15:0] w_ofs;
    logic [31:0] w_idx_ext;
    logic        w_tbl_wr;
    logic        w_hit;
    logic        w_full;
    logic        w_allowed;
    logic        w_cutting;
    logic [pht_pkg::CUT_W-1:0] w_hdr;
    logic [pht_pkg::CUT_W-1:0] w_cut;
    logic [15:0] w_cut_ext;
    logic        w_beyond;
    logic [15:0] w_new_len;
    logic [63:0] w_cnt_next;
    logic        w_cfg_wr;

    assign w_is_pkt      = (r_s1_op == pht_pkg::OP_BYTE);
    assign w_emits       = r_s1_vld && w_is_pkt && r_s1_last;
    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_s1_adv      = r_s1_vld && (!w_emits || w_out_free);
    assign s_axis_tready = !r_s1_vld || w_s1_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_op   <= s_axis_tuser;
            r_s1_byte <= s_axis_tdata[7:0];
            r_s1_last <= s_axis_tlast;
            r_s1_idx  <= s_axis_tdata[11:8];
            r_s1_addr <= s_axis_tdata[43:12];
            r_s1_evld <= s_axis_tdata[44];
        end
    end

    assign w_l3_ext = {{(16 - pht_pkg::L3_W){1'b0}}, r_l3};
    assign w_ofs    = r_pos - w_l3_ext;

    always_comb begin
        n_kind  = r_kind;
        n_tags  = r_tags;
        n_l3    = r_l3;
        n_phase = r_phase;
        n_hw    = r_hw;
        n_proto = r_proto;
        n_src   = r_src;
        n_pos   = (r_pos != 16'hFFFF) ? r_pos + 16'd1 : r_pos;
        case (r_phase)
            pht_pkg::PH_ETH: begin
                if (r_pos == w_l3_ext - 16'd2 || r_pos == w_l3_ext - 16'd1) begin
                    n_kind = {r_kind[7:0], r_s1_byte};
                end
                if (r_pos == w_l3_ext - 16'd1) begin
                    if ((n_kind == pht_pkg::ET_VLAN_Q || n_kind == pht_pkg::ET_VLAN_AD)
                        && (32'(r_tags) < 32'(pht_pkg::MAX_VLAN_TAGS))) begin
                        n_tags = r_tags + pht_pkg::TAG_W'(1);
                        n_l3   = r_l3 + pht_pkg::L3_W'(4);
                    end else if (n_kind == pht_pkg::ET_IPV4) begin
                        n_phase = pht_pkg::PH_V4;
                    end else if (n_kind == pht_pkg::ET_IPV6) begin
                        n_phase = pht_pkg::PH_V6;
                    end else begin
                        n_phase = pht_pkg::PH_OTHER;
                    end
                end
            end
            pht_pkg::PH_V4: begin
                if (w_ofs == pht_pkg::V4_OFS_VER) begin
                    n_hw = r_s1_byte[3:0];
                end else if (w_ofs == pht_pkg::V4_OFS_PROTO) begin
                    n_proto = r_s1_byte;
                end else if (w_ofs >= pht_pkg::V4_OFS_SRC_LO
                             && w_ofs <= pht_pkg::V4_OFS_SRC_HI) begin
                    n_src = {r_src[23:0], r_s1_byte};
                end
                if (w_ofs == pht_pkg::V4_OFS_END) begin
                    n_phase = pht_pkg::PH_V4_FULL;
                end
            end
            pht_pkg::PH_V6: begin
                if (w_ofs == pht_pkg::V6_OFS_PROTO) begin
                    n_proto = r_s1_byte;
                end
                if (w_ofs == pht_pkg::V6_OFS_END) begin
                    n_phase = pht_pkg::PH_V6_FULL;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_hit = 1'b0;
        for (int i = 0; i < pht_pkg::FILTER_ENTRIES; i++) begin
            if (r_tvld[i] && r_taddr[i] == r_src) begin
                w_hit = 1'b1;
            end
        end
    end

    assign w_full    = (n_phase == pht_pkg::PH_V4_FULL) || (n_phase == pht_pkg::PH_V6_FULL);
    assign w_allowed = (n_phase == pht_pkg::PH_V6_FULL) || !r_fen || w_hit;
    assign w_cutting = w_full && w_allowed
                       && (r_proto == pht_pkg::PROTO_UDP || r_proto == pht_pkg::PROTO_TCP);
    assign w_hdr     = (n_phase == pht_pkg::PH_V4_FULL)
                       ? pht_pkg::CUT_W'({r_hw, 2'b00})
                       : pht_pkg::CUT_W'(pht_pkg::IPV6_HDR_LEN);
    assign w_cut     = pht_pkg::CUT_W'(r_l3) + w_hdr
                       + ((r_proto == pht_pkg::PROTO_UDP)
                          ? pht_pkg::CUT_W'(pht_pkg::UDP_HDR_LEN)
                          : pht_pkg::CUT_W'(pht_pkg::TCP_HDR_LEN));
    assign w_cut_ext  = 16'(w_cut);
    assign w_beyond   = w_cut_ext > n_pos;
    assign w_new_len  = (w_cutting && !w_beyond) ? w_cut_ext : n_pos;
    assign w_cnt_next = w_cutting ? r_cnt + 64'd1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 16'd0;
            r_kind  <= 16'd0;
            r_tags  <= '0;
            r_l3    <= pht_pkg::L3_W'(pht_pkg::L3_BASE);
            r_phase <= pht_pkg::PH_ETH;
            r_hw    <= 4'd0;
            r_proto <= 8'd0;
            r_src   <= 32'd0;
        end else if (w_s1_adv && w_is_pkt) begin
            if (r_s1_last) begin
                r_pos   <= 16'd0;
                r_kind  <= 16'd0;
                r_tags  <= '0;
                r_l3    <= pht_pkg::L3_W'(pht_pkg::L3_BASE);
                r_phase <= pht_pkg::PH_ETH;
                r_hw    <= 4'd0;
                r_proto <= 8'd0;
                r_src   <= 32'd0;
            end else begin
                r_pos   <= n_pos;
                r_kind  <= n_kind;
                r_tags  <= n_tags;
                r_l3    <= n_l3;
                r_phase <= n_phase;
                r_hw    <= n_hw;
                r_proto <= n_proto;
                r_src   <= n_src;
            end
        end
    end

    assign w_idx_ext = {28'd0, r_s1_idx};
    assign w_tbl_wr  = w_s1_adv && !w_is_pkt
                       && (w_idx_ext < 32'(pht_pkg::FILTER_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (w_tbl_wr) begin
            r_taddr[w_idx_ext[pht_pkg::FILT_IDX_W-1:0]] <= r_s1_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pht_pkg::FILTER_ENTRIES; i++) begin
                r_tvld[i] <= 1'b0;
            end
        end else if (w_tbl_wr) begin
            r_tvld[w_idx_ext[pht_pkg::FILT_IDX_W-1:0]] <= r_s1_evld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= 64'd0;
            r_out_vld <= 1'b0;
        end else if (w_s1_adv && w_emits) begin
            r_cnt     <= w_cnt_next;
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv && w_emits) begin
            r_out_action <= w_cutting;
            r_out_len    <= w_new_len;
            r_out_beyond <= w_cutting && w_beyond;
            r_out_cnt    <= w_cnt_next;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_action;
    assign m_axis_tdata  = {7'd0, r_out_cnt, r_out_beyond, r_out_len};

    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == pht_pkg::APB_ADDR_FILTER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fen <= 1'b0;
        end else if (w_cfg_wr) begin
            r_fen <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pht_pkg::APB_ADDR_FILTER) ? {31'd0, r_fen} : 32'd0;

    a_beyond_needs_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_beyond) |-> r_out_action)
        else $error("cut_beyond_end set on a packet that was not cut");

    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_s1_adv) |=> r_s1_vld)
        else $error("stalled input beat was dropped");

    a_cnt_on_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_cnt != $past(r_cnt))
        |-> ($past(w_s1_adv) && $past(w_emits) && $past(w_cutting)))
        else $error("packet count moved without a cut packet");

endmodule
`default_nettype wire

// ----- tb/packet_header_truncator_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet header truncator testbench
// Streams Ethernet frames with VLAN tags, IPv4 and IPv6 headers and filter
// table updates into the truncator, predicts every cut decision alongside and
// checks each result beat field by field, under varied flow control.
// ----------------------------------------------------------------------------
module packet_header_truncator_unit_test;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int POOL_SIZE     = 8;
    localparam logic [pht_pkg::APB_AW-1:0] ADDR_FILTER_ENABLE = '0;
    localparam logic [15:0] ET_ARP = 16'h0806;

    typedef struct packed {
        logic        action;
        logic [15:0] new_length;
        logic        beyond_end;
        logic [63:0] cut_count;
    } t_cut_result;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    wire                           s_axis_tready;
    // data_byte[7:0], entry_index[11:8], entry_address[43:12], entry_valid[44]
    logic [pht_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    // operation
    logic                          s_axis_tuser  = pht_pkg::OP_BYTE;
    logic                          s_axis_tlast  = 1'b0;
    wire                           m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // new_length[15:0], cut_beyond_end[16], truncated_count[80:17]
    wire  [pht_pkg::M_TDATA_W-1:0] m_axis_tdata;
    // action
    wire                           m_axis_tuser;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [pht_pkg::APB_AW-1:0]    paddr         = '0;
    logic [31:0]                   pwdata        = '0;
    wire  [31:0]                   prdata;
    wire                           pready;

    // Shadow of the parser, the filter table and the running count.
    logic                       filter_on;
    logic [15:0]                rx_pos;
    logic [15:0]                rx_ethertype;
    int                         rx_tags;
    logic [pht_pkg::L3_W-1:0]   rx_l3;
    pht_pkg::t_phase            rx_phase;
    logic [3:0]                 rx_ihl;
    logic [7:0]                 rx_proto;
    logic [31:0]                rx_src;
    logic [31:0]                tbl_addr [pht_pkg::FILTER_ENTRIES];
    logic                       tbl_ok [pht_pkg::FILTER_ENTRIES];
    logic [63:0]                cut_total;
    t_cut_result                cut_results_q[$];

    logic [7:0]        frame_q[$];
    logic [31:0]       addr_pool [POOL_SIZE];
    int                mismatch_count = 0;
    int                beats_sent     = 0;
    int                idle_pct       = 0;
    int                stall_pct      = 0;
    int                mid_entry_pct  = 0;
    int                idle_cycles    = 0;
    int                hold_left      = 0;
    logic              hold_arm       = 1'b0;

    packet_header_truncator_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_parse();
        rx_pos       = '0;
        rx_ethertype = '0;
        rx_tags      = 0;
        rx_l3        = pht_pkg::L3_W'(pht_pkg::L3_BASE);
        rx_phase     = pht_pkg::PH_ETH;
        rx_ihl       = '0;
        rx_proto     = '0;
        rx_src       = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        int p;
        int l3;
        int ofs;
        p   = rx_pos;
        l3  = rx_l3;
        ofs = p - l3;
        case (rx_phase)
            pht_pkg::PH_ETH: begin
                if (p + 2 == l3 || p + 1 == l3) rx_ethertype = {rx_ethertype[7:0], b};
                if (p + 1 == l3) begin
                    if ((rx_ethertype == pht_pkg::ET_VLAN_Q
                         || rx_ethertype == pht_pkg::ET_VLAN_AD) &&
                        rx_tags < pht_pkg::MAX_VLAN_TAGS) begin
                        rx_tags++;
                        rx_l3 = rx_l3 + pht_pkg::L3_W'(4);
                    end else if (rx_ethertype == pht_pkg::ET_IPV4) begin
                        rx_phase = pht_pkg::PH_V4;
                    end else if (rx_ethertype == pht_pkg::ET_IPV6) begin
                        rx_phase = pht_pkg::PH_V6;
                    end else begin
                        rx_phase = pht_pkg::PH_OTHER;
                    end
                end
            end
            pht_pkg::PH_V4: begin
                if (ofs == int'(pht_pkg::V4_OFS_VER)) rx_ihl = b[3:0];
                else if (ofs == int'(pht_pkg::V4_OFS_PROTO)) rx_proto = b;
                else if (ofs >= int'(pht_pkg::V4_OFS_SRC_LO)
                         && ofs <= int'(pht_pkg::V4_OFS_SRC_HI))
                    rx_src = {rx_src[23:0], b};
                if (ofs == int'(pht_pkg::V4_OFS_END)) rx_phase = pht_pkg::PH_V4_FULL;
            end
            pht_pkg::PH_V6: begin
                if (ofs == int'(pht_pkg::V6_OFS_PROTO)) rx_proto = b;
                if (ofs == int'(pht_pkg::V6_OFS_END)) rx_phase = pht_pkg::PH_V6_FULL;
            end
            default: ;
        endcase
        if (rx_pos != 16'hFFFF) rx_pos++;
    endfunction

    function automatic void predict_beat(input logic op,
                                         input logic [pht_pkg::S_TDATA_W-1:0] d,
                                         input logic last);
        t_cut_result r;
        int          hdr;
        int          cut_at;
        logic        take;
        logic        allowed;
        if (op == pht_pkg::OP_ENTRY) begin
            tbl_addr[d[11:8]] = d[43:12];
            tbl_ok[d[11:8]]   = d[44];
            return;
        end
        parse_byte(d[7:0]);
        if (!last) return;
        take   = 1'b0;
        cut_at = 0;
        if (rx_phase == pht_pkg::PH_V4_FULL || rx_phase == pht_pkg::PH_V6_FULL) begin
            allowed = 1'b1;
            if (rx_phase == pht_pkg::PH_V4_FULL) begin
                hdr = int'(rx_ihl) * 4;
                if (filter_on) begin
                    allowed = 1'b0;
                    for (int i = 0; i < pht_pkg::FILTER_ENTRIES; i++)
                        if (tbl_ok[i] && tbl_addr[i] == rx_src) allowed = 1'b1;
                end
            end else begin
                hdr = int'(pht_pkg::IPV6_HDR_LEN);
            end
            if (allowed && rx_proto == pht_pkg::PROTO_UDP) begin
                take   = 1'b1;
                cut_at = int'(rx_l3) + hdr + int'(pht_pkg::UDP_HDR_LEN);
            end else if (allowed && rx_proto == pht_pkg::PROTO_TCP) begin
                take   = 1'b1;
                cut_at = int'(rx_l3) + hdr + int'(pht_pkg::TCP_HDR_LEN);
            end
        end
        r.action     = take;
        r.new_length = rx_pos;
        r.beyond_end = 1'b0;
        if (take) begin
            cut_total++;
            if (cut_at <= int'(rx_pos)) r.new_length = 16'(cut_at);
            else r.beyond_end = 1'b1;
        end
        r.cut_count = cut_total;
        cut_results_q.push_back(r);
        clear_parse();
    endfunction

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_and_predict
        t_cut_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cut_results_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result beat: expected none, actual %0d/%0d",
                             $time, m_axis_tuser, m_axis_tdata[15:0]);
                end else begin
                    want = cut_results_q.pop_front();
                    compare_field("action", want.action, m_axis_tuser);
                    compare_field("new_length", want.new_length, m_axis_tdata[15:0]);
                    compare_field("cut_beyond_end", want.beyond_end, m_axis_tdata[16]);
                    compare_field("truncated_count", want.cut_count, m_axis_tdata[80:17]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_beat(s_axis_tuser, s_axis_tdata, s_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (hold_arm) begin
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("packet_header_truncator_unit_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic op, input logic [pht_pkg::S_TDATA_W-1:0] d,
                             input logic last);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_entry(input logic [3:0] idx, input logic [31:0] addr,
                              input logic valid, input logic last);
        logic [pht_pkg::S_TDATA_W-1:0] d;
        d        = '0;
        d[7:0]   = 8'($urandom);
        d[11:8]  = idx;
        d[43:12] = addr;
        d[44]    = valid;
        send_beat(pht_pkg::OP_ENTRY, d, last);
    endtask

    task automatic send_random_entry(input logic last);
        logic [31:0] addr;
        addr = ($urandom_range(99) < 70) ? addr_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
        send_entry(4'($urandom), addr, $urandom_range(99) < 75, last);
    endtask

    task automatic send_frame(input int entry_at);
        for (int i = 0; i < frame_q.size(); i++) begin
            if (i == entry_at) send_random_entry(1'b1);
            else if (mid_entry_pct != 0 && $urandom_range(99) < mid_entry_pct)
                send_random_entry(1'($urandom_range(1)));
            send_beat(pht_pkg::OP_BYTE, pht_pkg::S_TDATA_W'(frame_q[i]),
                      i == frame_q.size() - 1);
        end
    endtask

    task automatic build_frame(input int ntags, input logic [15:0] etype, input logic [3:0] ihl,
                               input logic [7:0] proto, input logic [31:0] src,
                               input int total_len);
        logic [15:0] tpid;
        frame_q.delete();
        repeat (12) frame_q.push_back(8'($urandom));
        repeat (ntags) begin
            tpid = $urandom_range(1) ? pht_pkg::ET_VLAN_Q : pht_pkg::ET_VLAN_AD;
            frame_q.push_back(tpid[15:8]);
            frame_q.push_back(tpid[7:0]);
            frame_q.push_back(8'($urandom));
            frame_q.push_back(8'($urandom));
        end
        frame_q.push_back(etype[15:8]);
        frame_q.push_back(etype[7:0]);
        if (etype == pht_pkg::ET_IPV4) begin
            for (int i = 0; i < 20; i++) begin
                if (i == int'(pht_pkg::V4_OFS_VER)) frame_q.push_back({4'h4, ihl});
                else if (i == int'(pht_pkg::V4_OFS_PROTO)) frame_q.push_back(proto);
                else if (i >= int'(pht_pkg::V4_OFS_SRC_LO) && i <= int'(pht_pkg::V4_OFS_SRC_HI))
                    frame_q.push_back(src[8 * (int'(pht_pkg::V4_OFS_SRC_HI) - i) +: 8]);
                else frame_q.push_back(8'($urandom));
            end
        end else if (etype == pht_pkg::ET_IPV6) begin
            for (int i = 0; i < 40; i++) begin
                if (i == 0) frame_q.push_back({4'h6, 4'($urandom)});
                else if (i == int'(pht_pkg::V6_OFS_PROTO)) frame_q.push_back(proto);
                else frame_q.push_back(8'($urandom));
            end
        end
        while (frame_q.size() < total_len) frame_q.push_back(8'($urandom));
        while (frame_q.size() > total_len) void'(frame_q.pop_back());
    endtask

    task automatic random_frame(input int max_extra);
        int          pick;
        int          ntags;
        int          hdr_end;
        int          len;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] src;
        pick  = $urandom_range(99);
        ntags = (pick < 60) ? 0 : (pick < 80) ? 1 : (pick < 95) ? 2 : 3;
        pick  = $urandom_range(99);
        etype = (pick < 50) ? pht_pkg::ET_IPV4 : (pick < 80) ? pht_pkg::ET_IPV6 :
                (pick < 85) ? pht_pkg::ET_VLAN_AD : 16'($urandom);
        ihl   = ($urandom_range(99) < 60) ? 4'd5 : 4'($urandom);
        pick  = $urandom_range(99);
        proto = (pick < 45) ? pht_pkg::PROTO_UDP : (pick < 85) ? pht_pkg::PROTO_TCP :
                8'($urandom);
        src   = ($urandom_range(99) < 60) ? addr_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
        hdr_end = 14 + 4 * ntags + ((etype == pht_pkg::ET_IPV4) ? 20 :
                                    (etype == pht_pkg::ET_IPV6) ? 40 : 0);
        if ($urandom_range(99) < 80) len = hdr_end + $urandom_range(0, max_extra);
        else len = $urandom_range(1, hdr_end + 4);
        build_frame(ntags, etype, ihl, proto, src, len);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (cut_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_filter(input logic en);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FILTER_ENABLE;
        pwdata  <= {31'b0, en};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        filter_on = en;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {31'b0, en}) begin
            mismatch_count++;
            $display("%0t ns: filter_enable readback mismatch: expected %0d, actual %0d",
                     $time, en, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_directed_frames();
        idle_pct  = 0;
        stall_pct = 0;
        build_frame(0, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_UDP, $urandom, 46);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_TCP, $urandom, 54);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV4, 4'd15, pht_pkg::PROTO_UDP, $urandom, 40);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV4, 4'd0, pht_pkg::PROTO_UDP, $urandom, 34);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV4, 4'd5, 8'd1, $urandom, 34);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV6, 4'd0, pht_pkg::PROTO_UDP, 32'd0, 64);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV6, 4'd0, pht_pkg::PROTO_TCP, 32'd0, 54);
        send_frame(-1);
        build_frame(1, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_UDP, $urandom, 46);
        send_frame(-1);
        build_frame(2, pht_pkg::ET_IPV6, 4'd0, pht_pkg::PROTO_UDP, 32'd0, 62);
        send_frame(-1);
        build_frame(3, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_UDP, $urandom, 40);
        send_frame(-1);
        build_frame(0, ET_ARP, 4'd0, 8'd0, 32'd0, 20);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_UDP, $urandom, 24);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV6, 4'd0, pht_pkg::PROTO_TCP, 32'd0, 30);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_UDP, $urandom, 12);
        send_frame(-1);
        build_frame(1, pht_pkg::ET_IPV6, 4'd0, pht_pkg::PROTO_UDP, 32'd0, 16);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_UDP, $urandom, 1);
        send_frame(-1);
    endtask

    task automatic test_filter_table();
        idle_pct  = 9;
        stall_pct = 9;
        send_entry(4'd0, addr_pool[2], 1'b1, 1'b0);
        send_entry(4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_entry(4'd7, 32'h0000_0000, 1'b0, 1'b0);
        set_filter(1'b1);
        build_frame(0, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_UDP, addr_pool[2], 42);
        send_frame(20);
        build_frame(1, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_TCP, 32'hFFFF_FFFF, 58);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_UDP, 32'h0000_0000, 42);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_UDP,
                    addr_pool[3] ^ 32'h0000_0001, 42);
        send_frame(-1);
        build_frame(0, pht_pkg::ET_IPV6, 4'd0, pht_pkg::PROTO_UDP, 32'd0, 62);
        send_frame(-1);
        send_entry(4'd0, addr_pool[2], 1'b0, 1'b0);
        build_frame(0, pht_pkg::ET_IPV4, 4'd5, pht_pkg::PROTO_UDP, addr_pool[2], 42);
        send_frame(-1);
        send_entry(4'd0, 32'h0000_0000, 1'b1, 1'b0);
        build_frame(2, pht_pkg::ET_IPV4, 4'd6, pht_pkg::PROTO_TCP, 32'h0000_0000, 66);
        send_frame(-1);
        set_filter(1'b0);
    endtask

    task automatic test_output_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_arm <= 1'b1;
        @(posedge i_clk);
        hold_arm <= 1'b0;
        repeat (2) begin
            random_frame(4);
            send_frame(-1);
        end
        wait_idle();
    endtask

    task automatic run_random_phase(input int sender_idle, input int receiver_stall,
                                    input logic filt, input int min_beats);
        int start_beats;
        set_filter(filt);
        idle_pct      = sender_idle;
        stall_pct     = receiver_stall;
        mid_entry_pct = 3;
        start_beats   = beats_sent;
        while (beats_sent - start_beats < min_beats) begin
            if ($urandom_range(99) < 8) send_random_entry(1'($urandom_range(1)));
            random_frame(16);
            send_frame(-1);
        end
        mid_entry_pct = 0;
    endtask

    initial begin
        filter_on = 1'b0;
        cut_total = '0;
        for (int i = 0; i < pht_pkg::FILTER_ENTRIES; i++) begin
            tbl_addr[i] = '0;
            tbl_ok[i]   = 1'b0;
        end
        clear_parse();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_filter_table();
        test_output_backpressure();
        run_random_phase(0, 0, 1'b0, 40);
        run_random_phase(79, 0, 1'b1, 40);
        run_random_phase(0, 79, 1'b0, 40);
        run_random_phase(9, 9, 1'b1, 40);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("packet_header_truncator_unit_test: PASS");
        end else begin
            $display("packet_header_truncator_unit_test: FAIL");
        end
        $finish;
    end

endmodule
